[rtl/core/complex_integer_alu_assert.svh]
// Assertion macros for the complex integer ALU.
`ifndef COMPLEX_INTEGER_ALU_ASSERT_SVH
`define COMPLEX_INTEGER_ALU_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define CIA_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("complex_integer_alu assertion failed");
`define CIA_ASSERT_DELAY(lbl, clk_s, rst_s, ante, dly, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> ##(dly) (cons)) \
    else $error("complex_integer_alu latency assertion failed");
`else
`define CIA_ASSERT_IMPLY(lbl, clk_s, rst_s, ante, cons)
`define CIA_ASSERT_DELAY(lbl, clk_s, rst_s, ante, dly, cons)
`endif
`endif

[rtl/core/cia_pkg.sv]
// Package with widths, operation codes and stage control type for the complex ALU.
`default_nettype none
package cia_pkg;
  localparam int W       = 16;
  localparam int PW      = 2 * W;
  localparam int QW      = PW + 1;
  localparam int OUT_W   = 32;
  localparam int MW      = (QW > OUT_W + 1) ? QW : OUT_W + 1;
  localparam int LATENCY = QW + 4;

  typedef enum logic [1:0] {
    FUNC_ADD = 2'd0,
    FUNC_SUB = 2'd1,
    FUNC_MUL = 2'd2,
    FUNC_DIV = 2'd3
  } func_t;

  typedef struct packed {
    logic valid;
    logic div;
    logic zero;
    logic neg_re;
    logic neg_im;
  } ctrl_t;
endpackage
`default_nettype wire

[rtl/core/complex_integer_alu.sv]
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The quotient comes from a restoring divider, one quotient bit per stage.
// Reset (rst, synchronous) clears all valid bits; items in flight are dropped.
// Results show for one cycle with done high; the receiver cannot stall.
`default_nettype none
`include "complex_integer_alu_assert.svh"
module complex_integer_alu (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       func,
  input  wire logic signed [cia_pkg::W-1:0]     a_real,
  input  wire logic signed [cia_pkg::W-1:0]     a_imag,
  input  wire logic signed [cia_pkg::W-1:0]     b_real,
  input  wire logic signed [cia_pkg::W-1:0]     b_imag,
  output logic                                  done,
  output logic signed [cia_pkg::OUT_W-1:0]      res_real,
  output logic signed [cia_pkg::OUT_W-1:0]      res_imag,
  output logic                                  div_by_zero
);
  localparam int W  = cia_pkg::W;
  localparam int PW = cia_pkg::PW;
  localparam int QW = cia_pkg::QW;
  localparam int MW = cia_pkg::MW;
  localparam int OW = cia_pkg::OUT_W;

  assign busy = 1'b0;

  // Stage 1: capture operands
  logic                s1_valid;
  logic [1:0]          s1_func;
  logic signed [W-1:0] s1_p, s1_q, s1_r, s1_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
    s1_func <= func;
    s1_p    <= a_real;
    s1_q    <= a_imag;
    s1_r    <= b_real;
    s1_s    <= b_imag;
  end

  // Stage 2: partial products
  logic                 s2_valid;
  logic [1:0]           s2_func;
  logic signed [W-1:0]  s2_p, s2_q, s2_r, s2_s;
  logic signed [PW-1:0] s2_pr, s2_qs, s2_ps, s2_qr, s2_rr, s2_ss;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_func <= s1_func;
    s2_p    <= s1_p;
    s2_q    <= s1_q;
    s2_r    <= s1_r;
    s2_s    <= s1_s;
    s2_pr   <= s1_p * s1_r;
    s2_qs   <= s1_q * s1_s;
    s2_ps   <= s1_p * s1_s;
    s2_qr   <= s1_q * s1_r;
    s2_rr   <= s1_r * s1_r;
    s2_ss   <= s1_s * s1_s;
  end

  // Stage 3: combine into sign and magnitude, form the divisor
  logic signed [PW+1:0] v_re, v_im;
  logic [PW+1:0]        abs_re, abs_im;
  logic [PW-1:0]        den_c;
  logic                 zero_c;

  always_comb begin
    den_c  = PW'(s2_rr) + PW'(s2_ss);
    zero_c = (den_c == '0);
    case (cia_pkg::func_t'(s2_func))
      cia_pkg::FUNC_ADD: begin
        v_re = (PW+2)'(s2_p) + (PW+2)'(s2_r);
        v_im = (PW+2)'(s2_q) + (PW+2)'(s2_s);
      end
      cia_pkg::FUNC_SUB: begin
        v_re = (PW+2)'(s2_p) - (PW+2)'(s2_r);
        v_im = (PW+2)'(s2_q) - (PW+2)'(s2_s);
      end
      cia_pkg::FUNC_MUL: begin
        v_re = (PW+2)'(s2_pr) - (PW+2)'(s2_qs);
        v_im = (PW+2)'(s2_ps) + (PW+2)'(s2_qr);
      end
      default: begin
        v_re = (PW+2)'(s2_pr) + (PW+2)'(s2_qs);
        v_im = (PW+2)'(s2_qr) - (PW+2)'(s2_ps);
      end
    endcase
    abs_re = v_re[PW+1] ? (PW+2)'(-v_re) : (PW+2)'(v_re);
    abs_im = v_im[PW+1] ? (PW+2)'(-v_im) : (PW+2)'(v_im);
  end

  cia_pkg::ctrl_t ctl [QW+1];
  logic [QW-1:0]  quo_re [QW+1];
  logic [QW-1:0]  quo_im [QW+1];
  logic [PW-1:0]  rem_re [QW+1];
  logic [PW-1:0]  rem_im [QW+1];
  logic [PW-1:0]  den    [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl[0].valid <= 1'b0;
    end else begin
      ctl[0].valid <= s2_valid;
    end
    ctl[0].div    <= (s2_func == cia_pkg::FUNC_DIV);
    ctl[0].zero   <= (s2_func == cia_pkg::FUNC_DIV) && zero_c;
    ctl[0].neg_re <= v_re[PW+1];
    ctl[0].neg_im <= v_im[PW+1];
    quo_re[0]     <= ((s2_func == cia_pkg::FUNC_DIV) && zero_c) ? '0 : abs_re[QW-1:0];
    quo_im[0]     <= ((s2_func == cia_pkg::FUNC_DIV) && zero_c) ? '0 : abs_im[QW-1:0];
    rem_re[0]     <= '0;
    rem_im[0]     <= '0;
    den[0]        <= zero_c ? PW'(1) : den_c;
  end

  // Divider stages: one restoring step per stage, hold magnitude for other ops
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [PW:0] trial_re, trial_im;
    logic        ge_re, ge_im;

    always_comb begin
      trial_re = {rem_re[k], quo_re[k][QW-1]};
      trial_im = {rem_im[k], quo_im[k][QW-1]};
      ge_re    = (trial_re >= {1'b0, den[k]});
      ge_im    = (trial_im >= {1'b0, den[k]});
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[k+1].valid <= 1'b0;
      end else begin
        ctl[k+1].valid <= ctl[k].valid;
      end
      ctl[k+1].div    <= ctl[k].div;
      ctl[k+1].zero   <= ctl[k].zero;
      ctl[k+1].neg_re <= ctl[k].neg_re;
      ctl[k+1].neg_im <= ctl[k].neg_im;
      den[k+1]        <= den[k];
      if (ctl[k].div) begin
        quo_re[k+1] <= {quo_re[k][QW-2:0], ge_re};
        quo_im[k+1] <= {quo_im[k][QW-2:0], ge_im};
        rem_re[k+1] <= ge_re ? PW'(trial_re - {1'b0, den[k]}) : trial_re[PW-1:0];
        rem_im[k+1] <= ge_im ? PW'(trial_im - {1'b0, den[k]}) : trial_im[PW-1:0];
      end else begin
        quo_re[k+1] <= quo_re[k];
        quo_im[k+1] <= quo_im[k];
        rem_re[k+1] <= rem_re[k];
        rem_im[k+1] <= rem_im[k];
      end
    end
  end

  // Output stage: apply sign and saturate to the result width
  localparam logic [MW-1:0] POS_MAX = MW'({1'b0, {(OW-1){1'b1}}});
  localparam logic [MW-1:0] NEG_MAX = MW'({1'b1, {(OW-1){1'b0}}});

  logic [MW-1:0] m_re, m_im;
  logic [OW-1:0] o_re, o_im;

  always_comb begin
    m_re = MW'(quo_re[QW]);
    m_im = MW'(quo_im[QW]);
    if (!ctl[QW].neg_re) begin
      o_re = (m_re > POS_MAX) ? POS_MAX[OW-1:0] : m_re[OW-1:0];
    end else begin
      o_re = (m_re > NEG_MAX) ? NEG_MAX[OW-1:0] : OW'(-m_re);
    end
    if (!ctl[QW].neg_im) begin
      o_im = (m_im > POS_MAX) ? POS_MAX[OW-1:0] : m_im[OW-1:0];
    end else begin
      o_im = (m_im > NEG_MAX) ? NEG_MAX[OW-1:0] : OW'(-m_im);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl[QW].valid;
    end
    res_real    <= o_re;
    res_imag    <= o_im;
    div_by_zero <= ctl[QW].zero;
  end

  // Checks
  `CIA_ASSERT_IMPLY(a_zero_clears, clk, rst, done && div_by_zero, res_real == '0 && res_imag == '0)
  `CIA_ASSERT_DELAY(a_latency, clk, rst, start && !busy, cia_pkg::LATENCY, done)
  `CIA_ASSERT_IMPLY(a_zero_only_div, clk, rst, ctl[QW].zero, ctl[QW].div)
endmodule
`default_nettype wire

[sim/complex_integer_alu_tb.sv]
// Self-checking testbench for the complex integer ALU: random and corner items, scoreboard.
`default_nettype none
module complex_integer_alu_tb;

  typedef struct {
    cia_pkg::func_t     op;
    logic signed [15:0] ar, ai, br, bi;
  } cplx_op_t;

  typedef struct {
    logic signed [31:0] re, im;
    logic               dz;
  } cplx_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [1:0] func = '0;
  logic signed [15:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
  wire busy, done, div_by_zero;
  wire signed [31:0] res_real, res_imag;

  cplx_op_t  op_queue[$];
  cplx_res_t result_queue[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int n_dz = 0;
  int quiet_cycles = 0;
  int idle_pct = 38;
  bit hold_until_drained = 1'b0;

  complex_integer_alu dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .a_real(a_real), .a_imag(a_imag), .b_real(b_real), .b_imag(b_imag),
    .done(done), .res_real(res_real), .res_imag(res_imag), .div_by_zero(div_by_zero)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Clamp an exact value into the signed 32-bit result range
  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Divide truncating toward zero on magnitudes
  function automatic logic signed [63:0] div_trunc(input logic signed [63:0] n,
                                                    input logic signed [63:0] d);
    logic [63:0] mag;
    mag = (n < 0 ? -n : n) / d;
    return n < 0 ? -$signed(mag) : $signed(mag);
  endfunction

  // Compute the expected result of one item, clamped to the signed 32-bit range
  function automatic cplx_res_t complex_result(input cplx_op_t t);
    cplx_res_t r;
    logic signed [63:0] p, q, s, u, den, re, im;
    p = t.ar; q = t.ai; s = t.br; u = t.bi;
    r.dz = 1'b0;
    case (t.op)
      cia_pkg::FUNC_ADD: begin re = p + s; im = q + u; end
      cia_pkg::FUNC_SUB: begin re = p - s; im = q - u; end
      cia_pkg::FUNC_MUL: begin re = p * s - q * u; im = p * u + q * s; end
      default: begin
        den = s * s + u * u;
        if (den == 0) begin
          r.dz = 1'b1; re = 0; im = 0;
        end else begin
          re = div_trunc(p * s + q * u, den);
          im = div_trunc(q * s - p * u, den);
        end
      end
    endcase
    r.re = clamp32(re);
    r.im = clamp32(im);
    return r;
  endfunction

  function automatic logic signed [15:0] rand_operand();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sd0;
      3: return $signed(16'($urandom_range(0, 6) - 3));
      4: return $signed(16'($urandom_range(0, 510) - 255));
      default: return $signed(16'($urandom));
    endcase
  endfunction

  task automatic push_op(input cia_pkg::func_t op, input logic signed [15:0] ar, ai, br, bi);
    cplx_op_t t;
    t.op = op; t.ar = ar; t.ai = ai; t.br = br; t.bi = bi;
    op_queue.push_back(t);
  endtask

  // Drive items; hold start while an item waits and no pause applies
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        result_queue.push_back(complex_result('{cia_pkg::func_t'(func), a_real, a_imag,
                                               b_real, b_imag}));
        n_sent++;
      end
      if ((start && busy) ||
          (op_queue.size() != 0 && !(hold_until_drained && result_queue.size() != 0 &&
                                     !(start && !busy)) &&
           !(hold_until_drained && start && !busy) &&
           $urandom_range(0, 99) >= idle_pct)) begin
        if (!(start && busy)) begin
          cplx_op_t t;
          t = op_queue.pop_front();
          func <= t.op; a_real <= t.ar; a_imag <= t.ai; b_real <= t.br; b_imag <= t.bi;
        end
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      cplx_res_t e;
      if (result_queue.size() == 0) begin
        $display("%0t: unexpected result re=%0d im=%0d dz=%0b", $time, res_real,
                 res_imag, div_by_zero);
        errors++;
      end else begin
        e = result_queue.pop_front();
        n_recv++;
        if (div_by_zero) n_dz++;
        if (res_real !== e.re) begin
          $display("%0t: res_real expected %0d actual %0d", $time, e.re, res_real);
          errors++;
        end
        if (res_imag !== e.im) begin
          $display("%0t: res_imag expected %0d actual %0d", $time, e.im, res_imag);
          errors++;
        end
        if (div_by_zero !== e.dz) begin
          $display("%0t: div_by_zero expected %0b actual %0b", $time, e.dz, div_by_zero);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles with no handshake
  always @(posedge clk) begin
    if ((start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 2000) begin
      $display("%0t: timeout", $time);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    // Directed corners: extremes, every op, zero divisor, saturating product
    for (int f = 0; f < 4; f++) begin
      push_op(cia_pkg::func_t'(f), 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      push_op(cia_pkg::func_t'(f), 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
      push_op(cia_pkg::func_t'(f), -16'sd7, 16'sd3, 16'sd2, -16'sd1);
      push_op(cia_pkg::func_t'(f), 16'sh7FFF, 16'sh8000, 16'sd0, 16'sd0);
    end
    push_op(cia_pkg::FUNC_DIV, 16'sd1, -16'sd1, 16'sd3, 16'sd0);
    push_op(cia_pkg::FUNC_DIV, -16'sd5, 16'sd5, 16'sd0, -16'sd2);
    push_op(cia_pkg::FUNC_DIV, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    push_op(cia_pkg::FUNC_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (op_queue.size() == 0);
    // Pause until all corner results are back
    hold_until_drained = 1'b1;
    wait (result_queue.size() == 0 && !start);
    hold_until_drained = 1'b0;
    for (int i = 0; i < 1530; i++) begin
      logic signed [15:0] br, bi;
      br = rand_operand(); bi = rand_operand();
      if ($urandom_range(0, 19) == 0) begin br = 0; bi = 0; end
      push_op(cia_pkg::func_t'($urandom_range(0, 3)), rand_operand(), rand_operand(), br, bi);
    end
    // Keep a stretch with no idling in the middle
    wait (n_sent >= 520);
    idle_pct = 0;
    wait (n_sent >= 820);
    idle_pct = 38;
    wait (op_queue.size() == 0 && !start);
    wait (result_queue.size() == 0);
    repeat (cia_pkg::LATENCY + 10) @(posedge clk);
    $display("Covered %0d items over add, subtract, multiply and divide, %0d by zero.",
             n_sent, n_dz);
    if (errors == 0 && result_queue.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
`default_nettype wire
